### src/rotated_page_framebuffer_writer_macros.svh
// assertion helpers shared by the checker
`ifndef ROTATED_PAGE_FRAMEBUFFER_WRITER_MACROS_SVH
`define ROTATED_PAGE_FRAMEBUFFER_WRITER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPFW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RPFW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rpfw_pkg.sv
`timescale 1ns / 1ps

package rpfw_pkg;

    localparam int PANEL_WIDTH_DEF = 128;
    localparam int MAX_PAGES_DEF   = 8;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_SWAP  = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic REG_TALL_PANEL = 1'b0;
    localparam logic REG_ROTATION   = 1'b1;

    typedef struct packed {
        logic       drop;
        logic [2:0] page;
        logic [6:0] col;
        logic [2:0] bit_sel;
    } pix_target_t;

    // pages of the active panel height, capped by the storage
    function automatic logic [3:0] panel_pages(input logic tall, input int max_pages);
        logic [3:0] p;
        p = tall ? 4'd8 : 4'd4;
        if (int'(p) > max_pages)
        begin
            p = 4'(max_pages);
        end
        return p;
    endfunction

endpackage

### src/rotated_page_framebuffer_writer.sv
`timescale 1ns / 1ps

// put pixel and in-range byte read: memory read, then write-back or capture
// swap, dropped pixel, out-of-range read: finish on acceptance; clear: sweeps pages * PANEL_WIDTH bytes
// result enters the output register at the last edge of its request; one request at a time
// a result that finds the output register taken is held back and input stalls meanwhile
// reset zeroes both buffers, all 2 ** (1 + clog2(MAX_PAGES) + clog2(PANEL_WIDTH)) bytes
// (2048 by default), with s_tready low meanwhile; tall_panel resets to 1, rotation to 0, buffer to 0
module rotated_page_framebuffer_writer #(
    parameter int PANEL_WIDTH = rpfw_pkg::PANEL_WIDTH_DEF,
    parameter int MAX_PAGES   = rpfw_pkg::MAX_PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_x, pixel_y, pixel_on, read_page, read_column
    input  logic [31:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data, pixel_dropped
    output logic [15:0] m_tdata
);
    import rpfw_pkg::*;

    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int COL_W  = $clog2(PANEL_WIDTH);
    localparam int MEM_AW = 1 + PAGE_W + COL_W;
    localparam int DEPTH  = 2 ** MEM_AW;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_WIDTH - 1);
    localparam logic [7:0]       WIDTH_B  = 8'(PANEL_WIDTH);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RMW   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [7:0] pixel_store_reg [DEPTH];
    logic [7:0] mem_rdata_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    logic [2:0]        state_reg, state_next;
    logic              tall_reg;
    logic [1:0]        rot_reg;
    logic              cur_buf_reg, cur_buf_next;
    logic [MEM_AW-1:0] sweep_reg, sweep_next;
    logic [MEM_AW-1:0] tgt_addr_reg, tgt_addr_next;
    logic [7:0]        mask_reg, mask_next;
    logic              on_reg, on_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_drop_reg, res_drop_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_drop_reg, m_drop_next;

    logic [1:0]  cmd;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        pixel_on;
    logic [2:0]  read_page;
    logic [6:0]  read_column;
    pix_target_t target;
    logic [3:0]  pages;
    logic        rd_in_range;
    logic [MEM_AW-1:0] put_addr;
    logic [MEM_AW-1:0] rd_addr;
    logic        accept;
    logic        out_free;
    logic        fin;
    logic [7:0]  fin_data;
    logic        fin_drop;
    logic        push;
    logic        col_last;
    logic        page_last;
    logic [PAGE_W-1:0] page_inc;

    assign cmd         = s_tuser;
    assign pixel_x     = s_tdata[7:0];
    assign pixel_y     = s_tdata[15:8];
    assign pixel_on    = s_tdata[16];
    assign read_page   = s_tdata[19:17];
    assign read_column = s_tdata[26:20];

    rpfw_pixel_map #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .MAX_PAGES   (MAX_PAGES)
    ) u_map (
        .tall_panel    (tall_reg),
        .rotation_mode (rot_reg),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .target        (target)
    );

    assign pages       = panel_pages(tall_reg, MAX_PAGES);
    assign rd_in_range = ({1'b0, read_page} < pages) && ({1'b0, read_column} < WIDTH_B);
    assign put_addr    = {cur_buf_reg, target.page[PAGE_W-1:0], target.col[COL_W-1:0]};
    assign rd_addr     = {cur_buf_reg, read_page[PAGE_W-1:0], read_column[COL_W-1:0]};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign col_last  = (sweep_reg[COL_W-1:0] == COL_LAST);
    assign page_last = (4'(sweep_reg[COL_W +: PAGE_W]) == (pages - 4'd1));
    assign page_inc  = sweep_reg[COL_W +: PAGE_W] + PAGE_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        cur_buf_next  = cur_buf_reg;
        sweep_next    = sweep_reg;
        tgt_addr_next = tgt_addr_reg;
        mask_next     = mask_reg;
        on_next       = on_reg;
        res_data_next = res_data_reg;
        res_drop_next = res_drop_reg;
        mem_we        = 1'b0;
        mem_addr      = sweep_reg;
        mem_wdata     = 8'd0;
        fin           = 1'b0;
        fin_data      = 8'd0;
        fin_drop      = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + MEM_AW'(1);
                if (sweep_reg == {MEM_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                mem_addr = (cmd == CMD_READ) ? rd_addr : put_addr;
                if (accept)
                begin
                    case (cmd)
                        CMD_PUT:
                        begin
                            if (target.drop)
                            begin
                                fin      = 1'b1;
                                fin_drop = 1'b1;
                            end
                            else
                            begin
                                tgt_addr_next = put_addr;
                                mask_next     = 8'd1 << target.bit_sel;
                                on_next       = pixel_on;
                                state_next    = ST_RMW;
                            end
                        end
                        CMD_READ:
                        begin
                            if (rd_in_range)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            sweep_next = {cur_buf_reg, {(MEM_AW-1){1'b0}}};
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            cur_buf_next = ~cur_buf_reg;
                            fin          = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                mem_we    = 1'b1;
                mem_addr  = tgt_addr_reg;
                mem_wdata = on_reg ? (mem_rdata_reg | mask_reg) : (mem_rdata_reg & ~mask_reg);
                fin       = 1'b1;
            end
            ST_READ:
            begin
                fin      = 1'b1;
                fin_data = mem_rdata_reg;
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (col_last && page_last)
                begin
                    fin = 1'b1;
                end
                else if (col_last)
                begin
                    sweep_next = {sweep_reg[MEM_AW-1], page_inc, {COL_W{1'b0}}};
                end
                else
                begin
                    sweep_next = sweep_reg + MEM_AW'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // result goes straight out when the output slot is free, else it waits here
        if (fin)
        begin
            res_data_next = fin_data;
            res_drop_next = fin_drop;
            state_next    = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    assign push = (fin || (state_reg == ST_HOLD)) && out_free;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_drop_next  = m_drop_reg;
        if (push)
        begin
            m_valid_next = 1'b1;
            m_data_next  = fin ? fin_data : res_data_reg;
            m_drop_next  = fin ? fin_drop : res_drop_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_store_reg[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= pixel_store_reg[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            tall_reg    <= 1'b1;
            rot_reg     <= ROT_0;
            cur_buf_reg <= 1'b0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_buf_reg <= cur_buf_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && (cfg_index == REG_TALL_PANEL))
            begin
                tall_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == REG_ROTATION))
            begin
                rot_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_addr_reg <= tgt_addr_next;
        mask_reg     <= mask_next;
        on_reg       <= on_next;
        res_data_reg <= res_data_next;
        res_drop_reg <= res_drop_next;
        m_data_reg   <= m_data_next;
        m_drop_reg   <= m_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_drop_reg, m_data_reg};

endmodule

### src/rpfw_pixel_map.sv
`timescale 1ns / 1ps

module rpfw_pixel_map #(
    parameter int PANEL_WIDTH = rpfw_pkg::PANEL_WIDTH_DEF,
    parameter int MAX_PAGES   = rpfw_pkg::MAX_PAGES_DEF
) (
    input  logic                  tall_panel,
    input  logic [1:0]            rotation_mode,
    input  logic [7:0]            pixel_x,
    input  logic [7:0]            pixel_y,
    output rpfw_pkg::pix_target_t target
);
    import rpfw_pkg::*;

    localparam logic [8:0] W9 = 9'(PANEL_WIDTH);

    logic [3:0] pages;
    logic [8:0] h9;
    logic       x_ok;
    logic       y_ok;
    logic [8:0] wx;
    logic [8:0] hy;
    logic [8:0] tx;
    logic [8:0] ty;
    logic       pre_drop;

    always_comb
    begin
        pages = panel_pages(tall_panel, MAX_PAGES);
        h9    = {2'b00, pages, 3'b000};
        x_ok  = {1'b0, pixel_x} < W9;
        y_ok  = {1'b0, pixel_y} < h9;
        // mirrored terms, only meaningful when the matching coordinate is in range
        wx    = W9 - 9'd1 - {1'b0, pixel_x};
        hy    = h9 - 9'd1 - {1'b0, pixel_y};

        case (rotation_mode)
            ROT_90:
            begin
                tx       = {2'b00, pixel_y[7:1]};
                ty       = {1'b0, wx[8:1]};
                pre_drop = !x_ok;
            end
            ROT_180:
            begin
                tx       = wx;
                ty       = hy;
                pre_drop = !x_ok || !y_ok;
            end
            ROT_270:
            begin
                tx       = {1'b0, hy[8:1]};
                ty       = {2'b00, pixel_x[7:1]};
                pre_drop = !y_ok;
            end
            default:
            begin
                tx       = {1'b0, pixel_x};
                ty       = {1'b0, pixel_y};
                pre_drop = 1'b0;
            end
        endcase

        target.drop    = pre_drop || !(tx < W9) || !(ty < h9);
        target.page    = ty[5:3];
        target.col     = tx[6:0];
        target.bit_sel = ty[2:0];
    end

endmodule

### src/rpfw_checker.sv
`timescale 1ns / 1ps
`include "rotated_page_framebuffer_writer_macros.svh"

module rpfw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import rpfw_pkg::*;

    logic clear_req;

    assign clear_req = s_tvalid && s_tready && (s_tuser == CMD_CLEAR);

    // a stalled result stays offered
    `RPFW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result withdrawn")

    // a stalled result keeps its payload
    `RPFW_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed")

    // a clear request always walks the buffer, so input is closed in the next cycle
    `RPFW_ASSERT_NEXT(a_clear_busy, clear_req, !s_tready, "input open right after clear")

    // a dropped pixel never carries read data
    `RPFW_ASSERT_NOW(a_drop_no_data, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0, "drop with data")

endmodule

bind rotated_page_framebuffer_writer rpfw_checker u_rpfw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import rpfw_pkg::*;

    localparam int FB_BYTES    = MAX_PAGES_DEF * PANEL_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] px;
        logic [7:0] py;
        logic       on;
        logic [2:0] page;
        logic [6:0] col;
    } fb_request_t;

    typedef struct {
        logic [7:0] data;
        logic       dropped;
    } fb_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_TALL_PANEL;
    logic [1:0]  cfg_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic [1:0]  s_tuser = CMD_PUT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // mirror of the framebuffer
    logic [7:0]  fb_mem [0:2*FB_BYTES-1];
    logic        fb_sel;
    logic        cfg_tall;
    logic [1:0]  cfg_rot;

    fb_request_t request_queue [$];
    fb_reply_t   awaited_replies [$];
    fb_request_t on_bus;

    int gap_left = 0;
    int burst_left = 1;
    int errors = 0;
    int replies_seen = 0;
    int cycle_count = 0;
    int settings_used = 1;
    int n_puts = 0, n_drops = 0, n_reads = 0, n_nonzero = 0, n_clears = 0, n_swaps = 0;

    rotated_page_framebuffer_writer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // rotated target of a pixel; drop set when it falls off the panel
    function automatic void map_pixel(input int x, input int y, input logic tall,
                                      input logic [1:0] rot, output logic drop,
                                      output int page, output int col, output int bitn);
        int w;
        int h;
        int tx;
        int ty;
        w = PANEL_WIDTH_DEF;
        h = tall ? 64 : 32;
        if (h > MAX_PAGES_DEF * 8)
        begin
            h = MAX_PAGES_DEF * 8;
        end
        drop = 1'b0;
        tx = x;
        ty = y;
        case (rot)
            ROT_90:
            begin
                if (w - 1 - x < 0)
                begin
                    drop = 1'b1;
                end
                tx = y / 2;
                ty = (w - 1 - x) / 2;
            end
            ROT_180:
            begin
                tx = w - 1 - x;
                ty = h - 1 - y;
            end
            ROT_270:
            begin
                if (h - 1 - y < 0)
                begin
                    drop = 1'b1;
                end
                tx = (h - 1 - y) / 2;
                ty = x / 2;
            end
            default: ;
        endcase
        if (tx < 0 || ty < 0 || tx >= w || ty >= h)
        begin
            drop = 1'b1;
        end
        page = drop ? 0 : ty / 8;
        col  = drop ? 0 : tx;
        bitn = drop ? 0 : ty % 8;
    endfunction

    function automatic fb_reply_t apply_to_framebuffer(input fb_request_t r);
        fb_reply_t rep;
        logic drop;
        int pg;
        int cl;
        int bn;
        int pages;
        int base;
        int idx;
        rep.data = 8'd0;
        rep.dropped = 1'b0;
        pages = (cfg_tall ? 64 : 32) / 8;
        if (pages > MAX_PAGES_DEF)
        begin
            pages = MAX_PAGES_DEF;
        end
        base = fb_sel ? FB_BYTES : 0;
        case (r.cmd)
            CMD_PUT:
            begin
                n_puts++;
                map_pixel(r.px, r.py, cfg_tall, cfg_rot, drop, pg, cl, bn);
                rep.dropped = drop;
                if (drop)
                begin
                    n_drops++;
                end
                else
                begin
                    idx = base + pg * PANEL_WIDTH_DEF + cl;
                    fb_mem[idx][bn] = r.on;
                end
            end
            CMD_READ:
            begin
                n_reads++;
                if (r.page < pages && r.col < PANEL_WIDTH_DEF)
                begin
                    rep.data = fb_mem[base + r.page * PANEL_WIDTH_DEF + r.col];
                end
                if (rep.data != 8'd0)
                begin
                    n_nonzero++;
                end
            end
            CMD_CLEAR:
            begin
                n_clears++;
                for (int i = 0; i < pages * PANEL_WIDTH_DEF; i++)
                begin
                    fb_mem[base + i] = 8'd0;
                end
            end
            default:
            begin
                n_swaps++;
                fb_sel = ~fb_sel;
            end
        endcase
        return rep;
    endfunction

    function automatic fb_request_t make_request(input logic [1:0] cmd, input int x, input int y,
                                                 input logic on, input int page, input int col);
        fb_request_t r;
        r.cmd  = cmd;
        r.px   = x[7:0];
        r.py   = y[7:0];
        r.on   = on;
        r.page = page[2:0];
        r.col  = col[6:0];
        return r;
    endfunction

    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TALL_PANEL)
        begin
            cfg_tall = val[0];
        end
        else
        begin
            cfg_rot = val;
        end
    endtask

    task automatic queue_random(input int count);
        fb_request_t r;
        int sel;
        int pick;
        logic drop;
        int pg;
        int cl;
        int bn;
        int recent_pg [$];
        int recent_cl [$];
        for (int i = 0; i < count; i++)
        begin
            r = make_request(CMD_PUT, $urandom_range(0, 255), $urandom_range(0, 255),
                             1'($urandom_range(0, 1)), $urandom_range(0, 7),
                             $urandom_range(0, 127));
            sel = $urandom_range(0, 99);
            if (sel < 62)
            begin
                // mostly near the panel, some anywhere in the field range
                if ($urandom_range(0, 4) != 0)
                begin
                    r.px = 8'($urandom_range(0, 131));
                    r.py = 8'($urandom_range(0, 67));
                end
                map_pixel(r.px, r.py, cfg_tall, cfg_rot, drop, pg, cl, bn);
                if (!drop)
                begin
                    recent_pg.push_back(pg);
                    recent_cl.push_back(cl);
                    if (recent_pg.size() > 8)
                    begin
                        void'(recent_pg.pop_front());
                        void'(recent_cl.pop_front());
                    end
                end
            end
            else if (sel < 93)
            begin
                r.cmd = CMD_READ;
                // read back bytes that were just drawn into
                if (recent_pg.size() > 0 && $urandom_range(0, 2) != 0)
                begin
                    pick = $urandom_range(0, recent_pg.size() - 1);
                    r.page = 3'(recent_pg[pick]);
                    r.col  = 7'(recent_cl[pick]);
                end
            end
            else if (sel < 98)
            begin
                r.cmd = CMD_SWAP;
            end
            else
            begin
                r.cmd = CMD_CLEAR;
            end
            request_queue.push_back(r);
        end
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || awaited_replies.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        fb_reply_t rep;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 32'd0;
            s_tuser  <= CMD_PUT;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rep = apply_to_framebuffer(on_bus);
                awaited_replies.push_back(rep);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    on_bus = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, on_bus.col, on_bus.page, on_bus.on,
                                 on_bus.py, on_bus.px};
                    s_tuser  <= on_bus.cmd;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern re-drawn at random from four modes, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        fb_reply_t want;
        int mon_cycle;
        int stall_mode;
        int hold_left;
        int next_hold_at;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_cycle = 0;
            stall_mode = 0;
            hold_left = 0;
            next_hold_at = 400;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (awaited_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (m_tdata[7:0] !== want.data)
                    begin
                        errors++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.data, m_tdata[7:0]);
                    end
                    if (m_tdata[8] !== want.dropped)
                    begin
                        errors++;
                        $display("%0t: pixel_dropped expected %b actual %b",
                                 $time, want.dropped, m_tdata[8]);
                    end
                end
            end
            mon_cycle++;
            if (mon_cycle % 50 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left == 0 && replies_seen >= next_hold_at)
            begin
                hold_left = 300;
                next_hold_at += 900;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (mon_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rotated_page_framebuffer_writer regression: fail");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 2 * FB_BYTES; i++)
        begin
            fb_mem[i] = 8'd0;
        end
        fb_sel   = 1'b0;
        cfg_tall = 1'b1;
        cfg_rot  = ROT_0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: 128 x 64, no rotation
        request_queue.push_back(make_request(CMD_PUT, 0, 0, 1'b1, 7, 127));
        request_queue.push_back(make_request(CMD_PUT, 127, 63, 1'b1, 0, 0));
        request_queue.push_back(make_request(CMD_PUT, 128, 0, 1'b1, 0, 0));
        request_queue.push_back(make_request(CMD_PUT, 0, 64, 1'b1, 0, 0));
        request_queue.push_back(make_request(CMD_PUT, 255, 255, 1'b1, 7, 127));
        request_queue.push_back(make_request(CMD_READ, 255, 255, 1'b1, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 7, 127));
        request_queue.push_back(make_request(CMD_PUT, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(make_request(CMD_PUT, 5, 13, 1'b1, 3, 64));
        request_queue.push_back(make_request(CMD_READ, 170, 85, 1'b1, 1, 5));
        request_queue.push_back(make_request(CMD_SWAP, 255, 255, 1'b1, 7, 127));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 7, 127));
        request_queue.push_back(make_request(CMD_PUT, 3, 3, 1'b1, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 0, 3));
        request_queue.push_back(make_request(CMD_CLEAR, 255, 255, 1'b1, 7, 127));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 0, 3));
        request_queue.push_back(make_request(CMD_SWAP, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 7, 127));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 1, 5));
        request_queue.push_back(make_request(CMD_CLEAR, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(make_request(CMD_READ, 0, 0, 1'b0, 7, 127));
        request_queue.push_back(make_request(CMD_SWAP, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(make_request(CMD_PUT, 255, 0, 1'b0, 0, 0));
        wait_idle();

        // random phases over every height and rotation
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_TALL_PANEL, (p % 2 == 0) ? 2'd0 : 2'd1);
            write_reg(REG_ROTATION, 2'(p / 2));
            settings_used++;
            @(negedge clk);
            queue_random(216);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d requests over %0d height/rotation settings:", replies_seen,
                 settings_used);
        $display("  %0d pixel writes (%0d dropped), %0d reads (%0d nonzero), %0d clears, %0d swaps",
                 n_puts, n_drops, n_reads, n_nonzero, n_clears, n_swaps);
        if (errors == 0)
        begin
            $display("rotated_page_framebuffer_writer regression: pass");
        end
        else
        begin
            $display("rotated_page_framebuffer_writer regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/rpfw_pkg.sv
src/rpfw_pixel_map.sv
src/rotated_page_framebuffer_writer.sv
src/rpfw_checker.sv
tb/sv/testbench.sv
